// ===== hdl/sevf_pkg.sv =====
// ----------------------------------------------------------------------------
// sevf_pkg: shared types and constants of the sound event vote fusion block
// Field widths, register indexes, reset values, grade codes and
// sequencer states.
// ----------------------------------------------------------------------------
package sevf_pkg;

   // Field widths
   localparam int LABEL_W   = 4;
   localparam int CONF_W    = 16;
   localparam int TIME_W    = 63;
   localparam int TIMEOUT_W = 16;
   localparam int LEVEL_W   = 2;
   localparam int VOTES_W   = 8;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_FALL_LABEL       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FALL_THRESHOLD   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OTHER_THRESHOLD  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_URGENT_THRESHOLD = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FALL_TIMEOUT     = 3'd4;

   // Register reset values
   localparam logic [LABEL_W-1:0]   RST_FALL_LABEL       = 4'd0;
   localparam logic [CONF_W-1:0]    RST_FALL_THRESHOLD   = 16'd39321;
   localparam logic [CONF_W-1:0]    RST_OTHER_THRESHOLD  = 16'd32768;
   localparam logic [CONF_W-1:0]    RST_URGENT_THRESHOLD = 16'd58982;
   localparam logic [TIMEOUT_W-1:0] RST_FALL_TIMEOUT     = 16'd3000;

   // Execution level codes
   localparam logic [LEVEL_W-1:0] LVL_NONE   = 2'd0;
   localparam logic [LEVEL_W-1:0] LVL_NORMAL = 2'd1;
   localparam logic [LEVEL_W-1:0] LVL_URGENT = 2'd2;

   // Vote and fall rules
   localparam int MIN_FILL_FOR_VOTE   = 3;
   localparam int MIN_VOTES_FOR_ALARM = 2;
   localparam logic [VOTES_W-1:0] VOTES_MAX = 8'd255;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_DRAIN,
      ST_SCAN,
      ST_DECIDE,
      ST_FALL
   } state_type;

endpackage

// ===== hdl/sound_event_vote_fusion.sv =====
// Sequence: an accepted classify transaction walks READ, DRAIN, SCAN, DECIDE and FALL,
//    READ covering the history fill including the new label (at most HISTORY_DEPTH).
// New requests are stalled until the sequencer is back in IDLE; the single ring read port
//    and the single count-table port make the READ and SCAN passes run one entry at a time.
// A reset transaction gives no result.
// Reset: synchronous, active high; clears control, configuration and fall state.
// ----------------------------------------------------------------------------
// sound_event_vote_fusion: sliding-window majority vote with fall detection
// Grades classifier confidence, votes over a label history ring with one
// shared counter/compare unit, and runs the fall suspicion machine.
// ----------------------------------------------------------------------------
module sound_event_vote_fusion
   import sevf_pkg::*;
#(
   parameter int HISTORY_DEPTH = 8,
   parameter int NUM_CLASSES   = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   // configuration write port
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_func,
   input  logic [LABEL_W-1:0]    req_class_label,
   input  logic [CONF_W-1:0]     req_confidence,
   input  logic [TIME_W-1:0]     req_time_ms,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [LABEL_W-1:0]    rsp_fused_label,
   output logic [LEVEL_W-1:0]    rsp_urgency,
   output logic                  rsp_overridden,
   output logic                  rsp_need_prompt,
   output logic                  rsp_fall_alarm
);

   // Ring index, fill/count and class index widths
   localparam int RIW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int FW  = $clog2(HISTORY_DEPTH + 1);
   localparam int CIW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

   localparam logic [RIW-1:0]     LastSlot      = RIW'(HISTORY_DEPTH - 1);
   localparam logic [FW-1:0]      DepthFill     = FW'(HISTORY_DEPTH);
   localparam logic [FW-1:0]      MinFill       = FW'(MIN_FILL_FOR_VOTE);
   localparam logic [CIW-1:0]     LastClass     = CIW'(NUM_CLASSES - 1);
   localparam logic [LABEL_W:0]   NumClassesExt = (LABEL_W+1)'(NUM_CLASSES);
   localparam logic [VOTES_W-1:0] MinAlarmVotes = VOTES_W'(MIN_VOTES_FOR_ALARM);

   // ------------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------------
   logic [LABEL_W-1:0]   fall_label_ff;
   logic [CONF_W-1:0]    fall_th_ff;
   logic [CONF_W-1:0]    other_th_ff;
   logic [CONF_W-1:0]    urgent_th_ff;
   logic [TIMEOUT_W-1:0] timeout_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fall_label_ff <= RST_FALL_LABEL;
         fall_th_ff    <= RST_FALL_THRESHOLD;
         other_th_ff   <= RST_OTHER_THRESHOLD;
         urgent_th_ff  <= RST_URGENT_THRESHOLD;
         timeout_ff    <= RST_FALL_TIMEOUT;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FALL_LABEL:       fall_label_ff <= csr_wdata[LABEL_W-1:0];
            CSR_FALL_THRESHOLD:   fall_th_ff    <= csr_wdata[CONF_W-1:0];
            CSR_OTHER_THRESHOLD:  other_th_ff   <= csr_wdata[CONF_W-1:0];
            CSR_URGENT_THRESHOLD: urgent_th_ff  <= csr_wdata[CONF_W-1:0];
            CSR_FALL_TIMEOUT:     timeout_ff    <= csr_wdata[TIMEOUT_W-1:0];
            default: ;   // drop writes beyond the register list
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------------
   state_type state_ff, state_in;

   logic req_accept;
   logic classify_go;
   logic clear_go;
   logic rsp_free;
   logic rd_last;
   logic scan_last;
   logic rsp_load;

   logic [RIW-1:0] rd_idx_ff;
   logic [CIW-1:0] scan_idx_ff;
   logic [FW-1:0]  fill_ff;

   assign req_stall   = (state_ff != ST_IDLE);
   assign req_accept  = req_valid && !req_stall;
   assign classify_go = req_accept && !req_func;
   assign clear_go    = req_accept && req_func;
   assign rsp_free    = !rsp_valid || !rsp_stall;
   assign rd_last     = (FW'(rd_idx_ff) == (fill_ff - 1'b1));
   assign scan_last   = (scan_idx_ff == LastClass);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      rsp_load = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (classify_go) state_in = ST_READ;
         end
         ST_READ: begin
            if (rd_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_last) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            state_in = ST_FALL;
         end
         ST_FALL: begin
            // hold the finished result until the output register frees up
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------------------
   // Latched transaction and history control
   // ------------------------------------------------------------------------
   logic [LABEL_W-1:0] lab_ff;
   logic [CONF_W-1:0]  conf_ff;
   logic [TIME_W-1:0]  time_ff;
   logic [RIW-1:0]     wp_ff;

   always_ff @(posedge clock) begin
      if (classify_go) begin
         lab_ff  <= req_class_label;
         conf_ff <= req_confidence;
         time_ff <= req_time_ms;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear_go) begin
         wp_ff   <= '0;
         fill_ff <= '0;
      end else if (classify_go) begin
         wp_ff <= (wp_ff == LastSlot) ? '0 : wp_ff + 1'b1;
         if (fill_ff != DepthFill) fill_ff <= fill_ff + 1'b1;
      end
   end

   // Label ring: one write port at the write pointer, one registered read port
   logic [LABEL_W-1:0] ring_mem [HISTORY_DEPTH];
   logic [LABEL_W-1:0] ring_q_ff;
   logic               rd_vld_ff;

   always_ff @(posedge clock) begin
      if (classify_go) ring_mem[wp_ff] <= req_class_label;
      ring_q_ff <= ring_mem[rd_idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= (state_ff == ST_READ);
      end
   end

   always_ff @(posedge clock) begin
      if (classify_go) begin
         rd_idx_ff <= '0;
      end else if (state_ff == ST_READ && !rd_last) begin
         rd_idx_ff <= rd_idx_ff + 1'b1;
      end
   end

   // ------------------------------------------------------------------------
   // Class count table with a single read/modify port, shared by the count
   // pass and the scan pass
   // ------------------------------------------------------------------------
   logic [FW-1:0]  count_ff [NUM_CLASSES];
   logic [CIW-1:0] cnt_addr;
   logic [FW-1:0]  cnt_rd;
   logic           ring_lab_ok;
   logic           cnt_inc;

   assign ring_lab_ok = ({1'b0, ring_q_ff} < NumClassesExt);
   assign cnt_inc     = rd_vld_ff && ring_lab_ok;
   assign cnt_addr    = (state_ff == ST_SCAN) ? scan_idx_ff : ring_q_ff[CIW-1:0];
   assign cnt_rd      = count_ff[cnt_addr];

   always_ff @(posedge clock) begin
      if (classify_go) begin
         for (int i = 0; i < NUM_CLASSES; i++) count_ff[i] <= '0;
      end else if (cnt_inc) begin
         count_ff[cnt_addr] <= cnt_rd + 1'b1;
      end
   end

   // Scan: keep the first class with the highest count
   logic [FW-1:0]  best_c_ff;
   logic [CIW-1:0] best_idx_ff;

   always_ff @(posedge clock) begin
      if (classify_go) begin
         best_c_ff   <= '0;
         best_idx_ff <= '0;
         scan_idx_ff <= '0;
      end else if (state_ff == ST_SCAN) begin
         if (cnt_rd > best_c_ff) begin
            best_c_ff   <= cnt_rd;
            best_idx_ff <= scan_idx_ff;
         end
         if (!scan_last) scan_idx_ff <= scan_idx_ff + 1'b1;
      end
   end

   // ------------------------------------------------------------------------
   // Decide: vote threshold, grade and elapsed time
   //   best >= floor(2*fill/3)  is the same as  3*best + 2 >= 2*fill
   // ------------------------------------------------------------------------
   logic [FW+1:0]      vote_lhs;
   logic [FW+1:0]      vote_rhs;
   logic               vote_ok;
   logic [LABEL_W-1:0] best_lab;
   logic               fuse_now;
   logic [CONF_W-1:0]  lab_th;
   logic [LEVEL_W-1:0] level_now;
   logic [TIME_W:0]    elapsed;
   logic               over_now;

   logic [LABEL_W-1:0] final_ff;
   logic               fused_ff;
   logic [LEVEL_W-1:0] level_ff;
   logic               over_ff;

   assign vote_lhs = (FW+2)'({best_c_ff, 1'b0}) + (FW+2)'(best_c_ff) + (FW+2)'(2);
   assign vote_rhs = (FW+2)'({fill_ff, 1'b0});
   assign vote_ok  = (fill_ff >= MinFill) && (best_c_ff != '0) && (vote_lhs >= vote_rhs);
   assign best_lab = LABEL_W'(best_idx_ff);
   assign fuse_now = vote_ok && (best_lab != lab_ff);

   assign lab_th = (lab_ff == fall_label_ff) ? fall_th_ff : other_th_ff;

   always_comb begin
      if (conf_ff < lab_th) begin
         level_now = LVL_NONE;
      end else if (conf_ff < urgent_th_ff) begin
         level_now = LVL_NORMAL;
      end else begin
         level_now = LVL_URGENT;
      end
   end

   // Time going backwards shows as a borrow and never counts as a timeout
   logic [TIME_W-1:0] start_ff;

   assign elapsed  = {1'b0, time_ff} - {1'b0, start_ff};
   assign over_now = !elapsed[TIME_W]
                     && ((elapsed[TIME_W-1:TIMEOUT_W] != '0)
                         || (elapsed[TIMEOUT_W-1:0] > timeout_ff));

   always_ff @(posedge clock) begin
      if (state_ff == ST_DECIDE) begin
         final_ff <= fuse_now ? best_lab : lab_ff;
         fused_ff <= fuse_now;
         level_ff <= level_now;
         over_ff  <= over_now;
      end
   end

   // ------------------------------------------------------------------------
   // Fall machine, updated together with the result load
   // ------------------------------------------------------------------------
   logic               suspected_ff;
   logic [VOTES_W-1:0] votes_ff;
   logic               is_fall;
   logic               fall_run;
   logic [VOTES_W-1:0] votes_upd;
   logic               prompt_now;
   logic               alarm_now;

   assign is_fall   = (lab_ff == fall_label_ff) && (conf_ff > fall_th_ff);
   assign fall_run  = (final_ff == fall_label_ff) || (lab_ff == fall_label_ff);
   assign votes_upd = (is_fall && votes_ff != VOTES_MAX) ? votes_ff + 1'b1 : votes_ff;

   assign prompt_now = fall_run && !suspected_ff && is_fall;
   assign alarm_now  = fall_run && suspected_ff && over_ff && (votes_upd >= MinAlarmVotes);

   always_ff @(posedge clock) begin
      if (reset || clear_go) begin
         suspected_ff <= 1'b0;
      end else if (rsp_load && fall_run) begin
         if (!suspected_ff) begin
            if (is_fall) suspected_ff <= 1'b1;
         end else if (over_ff) begin
            suspected_ff <= 1'b0;
         end
      end
   end

   // Vote count and start time survive a reset transaction; entry reloads them
   always_ff @(posedge clock) begin
      if (reset) begin
         votes_ff <= '0;
         start_ff <= '0;
      end else if (rsp_load && fall_run) begin
         if (!suspected_ff) begin
            if (is_fall) begin
               votes_ff <= VOTES_W'(1);
               start_ff <= time_ff;
            end
         end else begin
            votes_ff <= votes_upd;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Output register
   // ------------------------------------------------------------------------
   logic               rsp_valid_ff;
   logic [LABEL_W-1:0] rsp_label_ff;
   logic [LEVEL_W-1:0] rsp_level_ff;
   logic               rsp_fused_ff;
   logic               rsp_prompt_ff;
   logic               rsp_alarm_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_label_ff  <= final_ff;
         rsp_level_ff  <= level_ff;
         rsp_fused_ff  <= fused_ff;
         rsp_prompt_ff <= prompt_now;
         rsp_alarm_ff  <= alarm_now;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_fused_label = rsp_label_ff;
   assign rsp_urgency     = rsp_level_ff;
   assign rsp_overridden  = rsp_fused_ff;
   assign rsp_need_prompt = rsp_prompt_ff;
   assign rsp_fall_alarm  = rsp_alarm_ff;

`ifndef SYNTHESIS
   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= DepthFill)
      else $error("history fill exceeds ring depth");

   a_read_in_fill: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> (FW'(rd_idx_ff) < fill_ff))
      else $error("ring read beyond written entries");

   a_rsp_from_fall: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_FALL))
      else $error("result raised outside the final step");

   a_prompt_alarm_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_need_prompt && rsp_fall_alarm))
      else $error("prompt and alarm on the same result");

   a_prompt_enters: assert property (@(posedge clock) disable iff (reset)
      rsp_load && prompt_now |=> suspected_ff)
      else $error("prompt without entering suspected");
`endif

endmodule

// ===== verif/sound_event_vote_fusion_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sound_event_vote_fusion_test: self-checking bench for the vote fusion block
// Drives classify and clear transactions through the request channel and
// mirrors the history vote, confidence grading and fall suspicion machine in
// a cycle-free model. Each response is compared field by field with the
// oldest predicted outcome. Directed cases come first, then a long vote-count
// saturation run, then random traffic over several register settings.
// Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module sound_event_vote_fusion_test
   import sevf_pkg::*;
();

   localparam int HISTORY_DEPTH = 8;
   localparam int NUM_CLASSES   = 16;
   localparam int DRAIN_CYCLES  = 40;
   localparam int CYCLE_LIMIT   = 600000;
   localparam logic [TIME_W-1:0] TIME_MAX = '1;

   typedef struct packed {
      logic [LABEL_W-1:0] fused_label;
      logic [LEVEL_W-1:0] urgency;
      logic               overridden;
      logic               need_prompt;
      logic               fall_alarm;
   } fusion_outcome_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   logic                  req_valid;
   logic                  req_stall;
   logic                  req_func;
   logic [LABEL_W-1:0]    req_class_label;
   logic [CONF_W-1:0]     req_confidence;
   logic [TIME_W-1:0]     req_time_ms;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [LABEL_W-1:0]    rsp_fused_label;
   logic [LEVEL_W-1:0]    rsp_urgency;
   logic                  rsp_overridden;
   logic                  rsp_need_prompt;
   logic                  rsp_fall_alarm;

   // Register shadow
   logic [LABEL_W-1:0]   cfg_fall_label;
   logic [CONF_W-1:0]    cfg_fall_threshold;
   logic [CONF_W-1:0]    cfg_other_threshold;
   logic [CONF_W-1:0]    cfg_urgent_threshold;
   logic [TIMEOUT_W-1:0] cfg_fall_timeout;

   // Mirror of the history ring and the fall machine
   logic [LABEL_W-1:0] hist_ring [HISTORY_DEPTH];
   int                 hist_wr;
   int                 hist_fill;
   logic               fall_armed;
   logic [TIME_W-1:0]  fall_t0;
   logic [VOTES_W-1:0] fall_count;

   fusion_outcome_type expected_outcomes[$];

   logic [TIME_W-1:0] now_ms;
   logic              no_idle;
   int                stall_run;
   int                cycle_count;
   int                errors;
   int                items_sent;
   int                outcomes_checked;
   int                fused_seen;
   int                prompts_seen;
   int                alarms_seen;
   int                settings_used;

   sound_event_vote_fusion #(
      .HISTORY_DEPTH (HISTORY_DEPTH),
      .NUM_CLASSES   (NUM_CLASSES)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_class_label (req_class_label),
      .req_confidence  (req_confidence),
      .req_time_ms     (req_time_ms),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_fused_label (rsp_fused_label),
      .rsp_urgency     (rsp_urgency),
      .rsp_overridden  (rsp_overridden),
      .rsp_need_prompt (rsp_need_prompt),
      .rsp_fall_alarm  (rsp_fall_alarm)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Hard stop in case the block hangs on a handshake.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: timeout after %0d cycles, %0d outcomes still pending",
               $time, cycle_count, expected_outcomes.size());
      $display("end of test: mismatches");
      $finish;
   end

   // Gap length shared by sender and receiver: mostly none or short, a few long.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 80) return $urandom_range(1, 3);
      if (roll < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Bias confidences toward the grading boundaries.
   function automatic logic [CONF_W-1:0] pick_confidence();
      logic [CONF_W-1:0] nudge;
      nudge = CONF_W'($urandom_range(0, 2)) - CONF_W'(1);
      case ($urandom_range(0, 5))
         0: return cfg_fall_threshold + nudge;
         1: return cfg_other_threshold + nudge;
         2: return cfg_urgent_threshold + nudge;
         3: return $urandom_range(0, 1) ? '1 : '0;
         default: return CONF_W'($urandom);
      endcase
   endfunction

   // Confidence that counts as a fall vote, when the threshold allows one.
   function automatic logic [CONF_W-1:0] pick_fall_confidence();
      if (cfg_fall_threshold == '1) return CONF_W'($urandom);
      return CONF_W'($urandom_range(cfg_fall_threshold + 1, 65535));
   endfunction

   // Work out the outcome of one accepted transaction and advance the mirror.
   task automatic predict_outcome(input logic func, input logic [LABEL_W-1:0] label,
                                  input logic [CONF_W-1:0] conf,
                                  input logic [TIME_W-1:0] stamp);
      fusion_outcome_type outcome;
      logic [CONF_W-1:0]  gate;
      int                 tally [NUM_CLASSES];
      int                 top;
      int                 top_count;
      logic               fall_vote;
      if (func) begin
         // clear: ring and machine go idle; votes and start time stay put
         hist_wr    = 0;
         hist_fill  = 0;
         fall_armed = 1'b0;
         return;
      end
      outcome = '0;
      outcome.fused_label = label;
      gate = (label == cfg_fall_label) ? cfg_fall_threshold : cfg_other_threshold;
      if (conf < gate)
         outcome.urgency = LVL_NONE;
      else if (conf < cfg_urgent_threshold)
         outcome.urgency = LVL_NORMAL;
      else
         outcome.urgency = LVL_URGENT;

      hist_ring[hist_wr] = label;
      hist_wr = (hist_wr + 1) % HISTORY_DEPTH;
      if (hist_fill < HISTORY_DEPTH) hist_fill++;

      // Modal label over the filled entries; the lowest label wins a tie.
      if (hist_fill >= MIN_FILL_FOR_VOTE) begin
         foreach (tally[c]) tally[c] = 0;
         for (int i = 0; i < hist_fill; i++)
            if (hist_ring[i] < NUM_CLASSES) tally[hist_ring[i]]++;
         top       = -1;
         top_count = 0;
         for (int c = 0; c < NUM_CLASSES; c++) begin
            if (tally[c] > top_count) begin
               top_count = tally[c];
               top       = c;
            end
         end
         if (top >= 0 && top_count >= (hist_fill * 2) / 3 && top != label) begin
            outcome.fused_label = LABEL_W'(top);
            outcome.overridden  = 1'b1;
         end
      end

      if (outcome.fused_label == cfg_fall_label || label == cfg_fall_label) begin
         fall_vote = (label == cfg_fall_label) && (conf > cfg_fall_threshold);
         if (!fall_armed) begin
            if (fall_vote) begin
               fall_armed          = 1'b1;
               fall_t0             = stamp;
               fall_count          = VOTES_W'(1);
               outcome.need_prompt = 1'b1;
            end
         end else begin
            if (fall_vote && fall_count != VOTES_MAX) fall_count++;
            // time running backwards never counts as a timeout
            if (stamp >= fall_t0 && (stamp - fall_t0) > cfg_fall_timeout) begin
               outcome.fall_alarm = (fall_count >= MIN_VOTES_FOR_ALARM);
               fall_armed         = 1'b0;
            end
         end
      end
      expected_outcomes.push_back(outcome);
   endtask

   // Present one transaction, hold it until accepted, then idle at random.
   task automatic send_item(input logic func, input logic [LABEL_W-1:0] label,
                            input logic [CONF_W-1:0] conf,
                            input logic [TIME_W-1:0] stamp);
      int gap;
      @(negedge clock);
      req_func        <= func;
      req_class_label <= label;
      req_confidence  <= conf;
      req_time_ms     <= stamp;
      req_valid       <= 1'b1;
      do @(posedge clock); while (req_stall);
      predict_outcome(func, label, conf, stamp);
      items_sent++;
      gap = no_idle ? 0 : pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // Drop valid and let every outstanding transaction finish.
   task automatic settle_block();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      case (index)
         CSR_FALL_LABEL:       cfg_fall_label       = data[LABEL_W-1:0];
         CSR_FALL_THRESHOLD:   cfg_fall_threshold   = data[CONF_W-1:0];
         CSR_OTHER_THRESHOLD:  cfg_other_threshold  = data[CONF_W-1:0];
         CSR_URGENT_THRESHOLD: cfg_urgent_threshold = data[CONF_W-1:0];
         CSR_FALL_TIMEOUT:     cfg_fall_timeout     = data[TIMEOUT_W-1:0];
         default: ;  // unused indexes are ignored by the block
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic apply_config(input logic [LABEL_W-1:0] fall_label,
                               input logic [CONF_W-1:0] fall_threshold,
                               input logic [CONF_W-1:0] other_threshold,
                               input logic [CONF_W-1:0] urgent_threshold,
                               input logic [TIMEOUT_W-1:0] fall_timeout);
      write_register(CSR_FALL_LABEL, CSR_DATA_W'(fall_label));
      write_register(CSR_FALL_THRESHOLD, fall_threshold);
      write_register(CSR_OTHER_THRESHOLD, other_threshold);
      write_register(CSR_URGENT_THRESHOLD, urgent_threshold);
      write_register(CSR_FALL_TIMEOUT, fall_timeout);
      settings_used++;
   endtask

   // Grade boundaries and vote override under the reset register values.
   task automatic test_reset_values();
      send_item(1'b0, 4'd1, 16'd32767, TIME_W'(0));
      send_item(1'b0, 4'd1, 16'd32768, TIME_W'(1));
      send_item(1'b0, 4'd1, 16'd58981, TIME_W'(2));
      // fall label at its threshold exactly: graded normal, but no fall vote
      send_item(1'b0, RST_FALL_LABEL, RST_FALL_THRESHOLD, TIME_W'(3));
      send_item(1'b0, RST_FALL_LABEL, RST_URGENT_THRESHOLD, TIME_W'(4));
      settle_block();
   endtask

   // Field extremes, ignored register indexes, zero timeout, backwards time.
   task automatic test_field_extremes();
      apply_config('1, '0, '1, '1, '0);
      // spare indexes must not disturb any register
      for (int k = CSR_FALL_TIMEOUT + 1; k < 2 ** CSR_IDX_W; k++)
         write_register(CSR_IDX_W'(k), '1);
      send_item(1'b1, '1, '1, TIME_MAX);
      send_item(1'b0, 4'd15, 16'd0, TIME_W'(0));
      send_item(1'b0, 4'd15, 16'd1, TIME_W'(0));
      send_item(1'b0, 4'd14, 16'hFFFF, TIME_W'(0));
      send_item(1'b0, 4'd0, 16'd0, TIME_MAX);
      send_item(1'b0, 4'd15, 16'hFFFF, TIME_MAX);
      send_item(1'b0, 4'd15, 16'hFFFF, TIME_W'(0));
      send_item(1'b0, 4'd15, 16'd0, TIME_MAX);
      send_item(1'b1, 4'd0, 16'd0, TIME_W'(0));
      send_item(1'b0, 4'd15, 16'd1, TIME_W'(5));
      send_item(1'b0, 4'd15, 16'd1, TIME_W'(6));
      settle_block();
   endtask

   // Prompt on entry, alarm with two votes, timeout with a single vote,
   // and a fall run entered through a fused label.
   task automatic test_fall_alarm();
      apply_config(4'd5, 16'd1000, 16'd0, 16'd40000, 16'd10);
      send_item(1'b1, 4'd0, 16'd0, TIME_W'(0));
      send_item(1'b0, 4'd5, 16'hFFFF, TIME_W'(100));
      send_item(1'b0, 4'd5, 16'd1001, TIME_W'(105));
      send_item(1'b0, 4'd5, 16'd1000, TIME_W'(90));
      send_item(1'b0, 4'd5, 16'd0, TIME_W'(111));
      send_item(1'b0, 4'd5, 16'd2000, TIME_W'(200));
      send_item(1'b0, 4'd3, 16'd0, TIME_W'(211));
      send_item(1'b0, 4'd3, 16'd39999, TIME_W'(212));
      settle_block();
   endtask

   // Hold the machine in suspicion for exactly 256 fall votes; the alarm
   // at the end only fires if the vote count saturates instead of wrapping.
   task automatic test_vote_saturation();
      logic [LABEL_W-1:0] fall_class;
      fall_class = LABEL_W'($urandom);
      apply_config(fall_class, CONF_W'($urandom_range(0, 60000)), CONF_W'($urandom),
                   CONF_W'($urandom), 16'd60000);
      now_ms = TIME_W'($urandom_range(0, 1000000));
      send_item(1'b1, fall_class, '0, now_ms);
      for (int n = 0; n < 256; n++) begin
         now_ms += $urandom_range(0, 100);
         send_item(1'b0, fall_class, pick_fall_confidence(), now_ms);
      end
      now_ms += 60001;
      send_item(1'b0, fall_class, '0, now_ms);
      settle_block();
   endtask

   // Random traffic over six register settings; mostly fall episodes and
   // label streaks, the rest noise and clears.
   task automatic test_random_traffic(input int target);
      int                 base;
      int                 len;
      int unsigned        step_max;
      logic [LABEL_W-1:0] label;
      base = items_sent;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: apply_config(RST_FALL_LABEL, RST_FALL_THRESHOLD, RST_OTHER_THRESHOLD,
                            RST_URGENT_THRESHOLD, RST_FALL_TIMEOUT);
            1: apply_config('1, '0, '0, '0, '0);
            2: apply_config(LABEL_W'($urandom), '1, '1, '1, 16'd60000);
            default: apply_config(LABEL_W'($urandom), CONF_W'($urandom), CONF_W'($urandom),
                                  CONF_W'($urandom), TIMEOUT_W'($urandom_range(0, 300)));
         endcase
         no_idle  = (phase == 3);
         step_max = cfg_fall_timeout / 2 + 1;
         while (items_sent - base < target * (phase + 1) / 6) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4: begin
                  // fall episode: votes within the window, then step past it
                  len = $urandom_range(1, 6);
                  for (int j = 0; j < len; j++) begin
                     now_ms += $urandom_range(0, step_max);
                     if ($urandom_range(0, 3) != 0)
                        send_item(1'b0, cfg_fall_label, pick_fall_confidence(), now_ms);
                     else
                        send_item(1'b0, LABEL_W'($urandom), pick_confidence(), now_ms);
                  end
                  now_ms += cfg_fall_timeout + 1 + $urandom_range(0, 20);
                  label = $urandom_range(0, 1) ? cfg_fall_label : LABEL_W'($urandom);
                  send_item(1'b0, label, pick_confidence(), now_ms);
               end
               5, 6, 7: begin
                  // streak of one label with a few intruders
                  label = LABEL_W'($urandom);
                  len = $urandom_range(3, 9);
                  for (int j = 0; j < len; j++) begin
                     now_ms += $urandom_range(0, step_max);
                     send_item(1'b0, ($urandom_range(0, 4) != 0) ? label : LABEL_W'($urandom),
                               pick_confidence(), now_ms);
                  end
               end
               8: begin
                  // noise: any label, any confidence, time may jump or go back
                  case ($urandom_range(0, 2))
                     0: now_ms = TIME_W'({$urandom, $urandom});
                     1: now_ms -= $urandom_range(0, 1000);
                     default: now_ms += $urandom_range(0, 100000);
                  endcase
                  send_item(1'b0, LABEL_W'($urandom), CONF_W'($urandom), now_ms);
               end
               default: send_item(1'b1, LABEL_W'($urandom), CONF_W'($urandom), now_ms);
            endcase
         end
         settle_block();
      end
      no_idle = 1'b0;
   endtask

   // Receiver back-pressure: random stall bursts, no new burst while no_idle is set.
   initial begin
      rsp_stall = 1'b0;
      stall_run = 0;
      forever begin
         @(negedge clock);
         if (stall_run == 0 && !no_idle && $urandom_range(0, 3) == 0)
            stall_run = pick_gap();
         rsp_stall <= (stall_run != 0);
         if (stall_run != 0) stall_run--;
      end
   end

   task automatic check_field(input string field, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
   endtask

   // Compare each accepted response with the oldest predicted outcome.
   always @(posedge clock) begin : rsp_monitor
      fusion_outcome_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_outcomes.size() == 0) begin
            errors++;
            $display("%0t: response with nothing outstanding, expected none, actual label %0d",
                     $time, rsp_fused_label);
         end else begin
            want = expected_outcomes.pop_front();
            check_field("fused_label", want.fused_label, rsp_fused_label);
            check_field("urgency", want.urgency, rsp_urgency);
            check_field("overridden", want.overridden, rsp_overridden);
            check_field("need_prompt", want.need_prompt, rsp_need_prompt);
            check_field("fall_alarm", want.fall_alarm, rsp_fall_alarm);
            outcomes_checked++;
            fused_seen   += rsp_overridden;
            prompts_seen += rsp_need_prompt;
            alarms_seen  += rsp_fall_alarm;
         end
      end
   end

   initial begin
      reset           = 1'b1;
      csr_we          = 1'b0;
      csr_index       = '0;
      csr_wdata       = '0;
      req_valid       = 1'b0;
      req_func        = 1'b0;
      req_class_label = '0;
      req_confidence  = '0;
      req_time_ms     = '0;
      no_idle         = 1'b0;
      now_ms          = '0;
      errors          = 0;
      items_sent      = 0;
      outcomes_checked = 0;
      fused_seen      = 0;
      prompts_seen    = 0;
      alarms_seen     = 0;
      settings_used   = 1;
      // mirror starts from the reset register values and an empty history
      cfg_fall_label       = RST_FALL_LABEL;
      cfg_fall_threshold   = RST_FALL_THRESHOLD;
      cfg_other_threshold  = RST_OTHER_THRESHOLD;
      cfg_urgent_threshold = RST_URGENT_THRESHOLD;
      cfg_fall_timeout     = RST_FALL_TIMEOUT;
      foreach (hist_ring[i]) hist_ring[i] = '0;
      hist_wr    = 0;
      hist_fill  = 0;
      fall_armed = 1'b0;
      fall_t0    = '0;
      fall_count = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_values();
      test_field_extremes();
      test_fall_alarm();
      test_vote_saturation();
      test_random_traffic(120);

      $display("run covered %0d request transactions over %0d register settings",
               items_sent, settings_used);
      $display("%0d responses checked: %0d vote overrides, %0d prompts, %0d alarms",
               outcomes_checked, fused_seen, prompts_seen, alarms_seen);
      if (errors == 0 && expected_outcomes.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
